FILE: src/vau_pkg.sv
package vau_pkg;

    // Component format: signed fixed point, CW bits with FB fraction bits.
    localparam int CW = 32;
    localparam int FB = 16;
    // Full product, product sum with headroom, dividend and quotient widths.
    localparam int PW = 2 * CW;
    localparam int SW = PW + 2;
    localparam int DW = CW + FB;

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [SW-1:0] CMAX_S = SW'(CMAX);
    localparam logic signed [SW-1:0] CMIN_S = SW'(CMIN);
    localparam logic signed [CW:0] CMAX_A = (CW+1)'(CMAX);
    localparam logic signed [CW:0] CMIN_A = (CW+1)'(CMIN);

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_SCALE = 4'd2,
        OP_DIV   = 4'd3,
        OP_CROSS = 4'd4,
        OP_DOT   = 4'd5,
        OP_LSQ   = 4'd6,
        OP_MAG   = 4'd7,
        OP_NORM  = 4'd8
    } op_t;

    // Everything an item carries down the pipeline besides the unit-local state.
    typedef struct packed {
        op_t                   op;
        logic signed [CW-1:0]  ax;
        logic signed [CW-1:0]  ay;
        logic signed [CW-1:0]  az;
        logic signed [CW-1:0]  s;
        logic signed [CW-1:0]  rx;
        logic signed [CW-1:0]  ry;
        logic signed [CW-1:0]  rz;
        logic signed [CW-1:0]  sc;
        logic                  ovf;
        logic [CW-1:0]         root;
    } pipe_t;

    typedef struct packed {
        logic [CW-1:0] val;
        logic          ovf;
    } sat_t;

    // Floor-shift a product sum by the fraction width and clamp it.
    function automatic sat_t sat_shift(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] sh;
        sat_t r;
        sh = v >>> FB;
        if (sh > CMAX_S) begin
            r.val = CMAX;
            r.ovf = 1'b1;
        end else if (sh < CMIN_S) begin
            r.val = CMIN;
            r.ovf = 1'b1;
        end else begin
            r.val = sh[CW-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    function automatic sat_t sat_add(input logic signed [CW:0] v);
        sat_t r;
        if (v > CMAX_A) begin
            r.val = CMAX;
            r.ovf = 1'b1;
        end else if (v < CMIN_A) begin
            r.val = CMIN;
            r.ovf = 1'b1;
        end else begin
            r.val = v[CW-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [CW-1:0] abs_c(input logic signed [CW-1:0] v);
        return v[CW-1] ? CW'(-v) : v;
    endfunction

    // Apply the sign to a quotient magnitude and clamp it.
    function automatic sat_t quot_sat(input logic [DW-1:0] q, input logic neg);
        sat_t r;
        if (!neg) begin
            r.ovf = (q > DW'(CMAX));
            r.val = r.ovf ? CMAX : q[CW-1:0];
        end else begin
            r.ovf = (q > (DW'(1) << (CW - 1)));
            r.val = r.ovf ? CMIN : CW'(-q[CW-1:0]);
        end
        return r;
    endfunction

endpackage

FILE: src/vau_front.sv
module vau_front
    import vau_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [3:0]            operation,
    input  logic signed [CW-1:0]  ax,
    input  logic signed [CW-1:0]  ay,
    input  logic signed [CW-1:0]  az,
    input  logic signed [CW-1:0]  bx,
    input  logic signed [CW-1:0]  by,
    input  logic signed [CW-1:0]  bz,
    input  logic signed [CW-1:0]  scale_value,
    output logic                  out_valid,
    output pipe_t                 out_pipe,
    output logic [PW-1:0]         out_sq
);

    // Stage 1: input register.
    logic                  v1_reg;
    pipe_t                 p1_reg;
    pipe_t                 p1_next;
    logic signed [CW-1:0]  bx1_reg, by1_reg, bz1_reg;

    // Stage 2: products and add/sub results.
    logic                  v2_reg;
    pipe_t                 p2_reg;
    pipe_t                 p2_next;
    logic signed [PW-1:0]  prod_reg  [6];
    logic signed [PW-1:0]  prod_next [6];

    // Stage 3: product sums.
    logic                  v3_reg;
    pipe_t                 p3_reg;
    logic signed [SW-1:0]  sum_reg  [4];
    logic signed [SW-1:0]  sum_next [4];

    // Stage 4: scaled and clamped results, sum of squares.
    logic                  v4_reg;
    pipe_t                 p4_reg;
    pipe_t                 p4_next;
    logic [PW-1:0]         sq_reg;
    logic [PW-1:0]         sq_next;

    always_comb
    begin
        p1_next      = '0;
        p1_next.op   = op_t'(operation);
        p1_next.ax   = ax;
        p1_next.ay   = ay;
        p1_next.az   = az;
        p1_next.s    = scale_value;
    end

    always_comb
    begin
        logic signed [CW-1:0] ma [6];
        logic signed [CW-1:0] mb [6];
        sat_t ex, ey, ez;
        for (int k = 0; k < 6; k++)
        begin
            ma[k] = '0;
            mb[k] = '0;
        end
        unique case (p1_reg.op) inside
            OP_SCALE:
            begin
                ma[0] = p1_reg.ax; mb[0] = p1_reg.s;
                ma[1] = p1_reg.ay; mb[1] = p1_reg.s;
                ma[2] = p1_reg.az; mb[2] = p1_reg.s;
            end
            OP_CROSS:
            begin
                ma[0] = p1_reg.ay; mb[0] = bz1_reg;
                ma[1] = p1_reg.az; mb[1] = by1_reg;
                ma[2] = p1_reg.az; mb[2] = bx1_reg;
                ma[3] = p1_reg.ax; mb[3] = bz1_reg;
                ma[4] = p1_reg.ax; mb[4] = by1_reg;
                ma[5] = p1_reg.ay; mb[5] = bx1_reg;
            end
            OP_DOT:
            begin
                ma[0] = p1_reg.ax; mb[0] = bx1_reg;
                ma[1] = p1_reg.ay; mb[1] = by1_reg;
                ma[2] = p1_reg.az; mb[2] = bz1_reg;
            end
            OP_LSQ, OP_MAG, OP_NORM:
            begin
                ma[0] = p1_reg.ax; mb[0] = p1_reg.ax;
                ma[1] = p1_reg.ay; mb[1] = p1_reg.ay;
                ma[2] = p1_reg.az; mb[2] = p1_reg.az;
            end
            default:
            begin
            end
        endcase
        for (int k = 0; k < 6; k++)
        begin
            prod_next[k] = PW'(ma[k]) * PW'(mb[k]);
        end

        p2_next = p1_reg;
        if (p1_reg.op == OP_SUB)
        begin
            ex = sat_add((CW+1)'(p1_reg.ax) - (CW+1)'(bx1_reg));
            ey = sat_add((CW+1)'(p1_reg.ay) - (CW+1)'(by1_reg));
            ez = sat_add((CW+1)'(p1_reg.az) - (CW+1)'(bz1_reg));
        end
        else
        begin
            ex = sat_add((CW+1)'(p1_reg.ax) + (CW+1)'(bx1_reg));
            ey = sat_add((CW+1)'(p1_reg.ay) + (CW+1)'(by1_reg));
            ez = sat_add((CW+1)'(p1_reg.az) + (CW+1)'(bz1_reg));
        end
        if (p1_reg.op == OP_ADD || p1_reg.op == OP_SUB)
        begin
            p2_next.rx  = ex.val;
            p2_next.ry  = ey.val;
            p2_next.rz  = ez.val;
            p2_next.ovf = ex.ovf | ey.ovf | ez.ovf;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sum_next[k] = '0;
        end
        unique case (p2_reg.op) inside
            OP_SCALE:
            begin
                sum_next[0] = SW'(prod_reg[0]);
                sum_next[1] = SW'(prod_reg[1]);
                sum_next[2] = SW'(prod_reg[2]);
            end
            OP_CROSS:
            begin
                sum_next[0] = SW'(prod_reg[0]) - SW'(prod_reg[1]);
                sum_next[1] = SW'(prod_reg[2]) - SW'(prod_reg[3]);
                sum_next[2] = SW'(prod_reg[4]) - SW'(prod_reg[5]);
            end
            OP_DOT, OP_LSQ, OP_MAG, OP_NORM:
            begin
                sum_next[3] = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        sat_t sx, sy, sz, ss;
        sx = sat_shift(sum_reg[0]);
        sy = sat_shift(sum_reg[1]);
        sz = sat_shift(sum_reg[2]);
        ss = sat_shift(sum_reg[3]);
        p4_next = p3_reg;
        sq_next = sum_reg[3][PW-1:0];
        unique case (p3_reg.op) inside
            OP_SCALE, OP_CROSS:
            begin
                p4_next.rx  = sx.val;
                p4_next.ry  = sy.val;
                p4_next.rz  = sz.val;
                p4_next.ovf = sx.ovf | sy.ovf | sz.ovf;
            end
            OP_DOT, OP_LSQ:
            begin
                p4_next.sc  = ss.val;
                p4_next.ovf = ss.ovf;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= p1_next;
            bx1_reg <= bx;
            by1_reg <= by;
            bz1_reg <= bz;
            p2_reg  <= p2_next;
            for (int k = 0; k < 6; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            p3_reg <= p2_reg;
            for (int k = 0; k < 4; k++)
            begin
                sum_reg[k] <= sum_next[k];
            end
            p4_reg <= p4_next;
            sq_reg <= sq_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_pipe  = p4_reg;
    assign out_sq    = sq_reg;

endmodule

FILE: src/vau_sqrt.sv
module vau_sqrt
    import vau_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  pipe_t          in_pipe,
    input  logic [PW-1:0]  in_sq,
    output logic           out_valid,
    output pipe_t          out_pipe
);

    // One root bit per stage; the root builds up in the root field of the item.
    logic            v_reg   [CW];
    pipe_t           p_reg   [CW];
    logic [PW-1:0]   n_reg   [CW];
    logic [CW+1:0]   rem_reg [CW];

    genvar i;
    for (i = 0; i < CW; i++)
    begin : g_stage
        logic           vi;
        pipe_t          pi;
        pipe_t          po;
        logic [PW-1:0]  ni;
        logic [CW+1:0]  ri;
        logic [CW+1:0]  ro;

        if (i == 0)
        begin : g_first
            always_comb
            begin
                vi      = in_valid;
                pi      = in_pipe;
                pi.root = '0;
                ni      = in_sq;
                ri      = '0;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                vi = v_reg[i-1];
                pi = p_reg[i-1];
                ni = n_reg[i-1];
                ri = rem_reg[i-1];
            end
        end

        always_comb
        begin
            logic [CW+3:0] t;
            logic [CW+3:0] trial;
            logic [CW+3:0] diff;
            logic          ge;
            t       = {ri, ni[PW-1 -: 2]};
            trial   = {2'b00, pi.root, 2'b01};
            diff    = t - trial;
            ge      = (t >= trial);
            po      = pi;
            po.root = {pi.root[CW-2:0], ge};
            ro      = ge ? diff[CW+1:0] : t[CW+1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[i]   <= po;
                n_reg[i]   <= {ni[PW-3:0], 2'b00};
                rem_reg[i] <= ro;
            end
        end
    end

    assign out_valid = v_reg[CW-1];
    assign out_pipe  = p_reg[CW-1];

endmodule

FILE: src/vau_div.sv
module vau_div
    import vau_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  pipe_t          in_pipe,
    output logic           out_valid,
    output pipe_t          out_pipe,
    output logic [DW-1:0]  out_qx,
    output logic [DW-1:0]  out_qy,
    output logic [DW-1:0]  out_qz
);

    // Restoring division of the three magnitudes by one shared divisor,
    // one quotient bit per stage.
    logic            v_reg   [DW];
    pipe_t           p_reg   [DW];
    logic [CW-1:0]   d_reg   [DW];
    logic [CW-1:0]   rem_reg [DW][3];
    logic [DW-1:0]   num_reg [DW][3];
    logic [DW-1:0]   q_reg   [DW][3];

    genvar i;
    for (i = 0; i < DW; i++)
    begin : g_stage
        logic           vi;
        pipe_t          pi;
        logic [CW-1:0]  di;
        logic [CW-1:0]  ri [3];
        logic [DW-1:0]  ni [3];
        logic [DW-1:0]  qi [3];
        logic [CW-1:0]  ro [3];
        logic [DW-1:0]  qo [3];

        if (i == 0)
        begin : g_first
            always_comb
            begin
                vi    = in_valid;
                pi    = in_pipe;
                di    = (in_pipe.op == OP_DIV) ? abs_c(in_pipe.s) : in_pipe.root;
                ni[0] = DW'(abs_c(in_pipe.ax)) << FB;
                ni[1] = DW'(abs_c(in_pipe.ay)) << FB;
                ni[2] = DW'(abs_c(in_pipe.az)) << FB;
                for (int k = 0; k < 3; k++)
                begin
                    ri[k] = '0;
                    qi[k] = '0;
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                vi = v_reg[i-1];
                pi = p_reg[i-1];
                di = d_reg[i-1];
                for (int k = 0; k < 3; k++)
                begin
                    ri[k] = rem_reg[i-1][k];
                    ni[k] = num_reg[i-1][k];
                    qi[k] = q_reg[i-1][k];
                end
            end
        end

        always_comb
        begin
            logic [CW:0] t;
            logic [CW:0] diff;
            logic        ge;
            for (int k = 0; k < 3; k++)
            begin
                t     = {ri[k], ni[k][DW-1]};
                diff  = t - {1'b0, di};
                ge    = (t >= {1'b0, di});
                ro[k] = ge ? diff[CW-1:0] : t[CW-1:0];
                qo[k] = {qi[k][DW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[i] <= pi;
                d_reg[i] <= di;
                for (int k = 0; k < 3; k++)
                begin
                    rem_reg[i][k] <= ro[k];
                    num_reg[i][k] <= {ni[k][DW-2:0], 1'b0};
                    q_reg[i][k]   <= qo[k];
                end
            end
        end
    end

    assign out_valid = v_reg[DW-1];
    assign out_pipe  = p_reg[DW-1];
    assign out_qx    = q_reg[DW-1][0];
    assign out_qy    = q_reg[DW-1][1];
    assign out_qz    = q_reg[DW-1][2];

endmodule

FILE: src/vector3_arithmetic_unit.sv
// Pipeline: 4 front stages, 32 square-root stages, 48 divider stages and
// 1 output register lie between input acceptance and result valid.
// Throughput: one request per cycle while the output register is empty or
// being taken; the whole pipeline holds as one when it is full and stalled.
// Reset (rst_n, asynchronous, active low) clears every stage's valid bit.
module vector3_arithmetic_unit
    import vau_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [3:0]            operation,
    input  logic signed [CW-1:0]  ax,
    input  logic signed [CW-1:0]  ay,
    input  logic signed [CW-1:0]  az,
    input  logic signed [CW-1:0]  bx,
    input  logic signed [CW-1:0]  by,
    input  logic signed [CW-1:0]  bz,
    input  logic signed [CW-1:0]  scale_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [CW-1:0]  rx,
    output logic signed [CW-1:0]  ry,
    output logic signed [CW-1:0]  rz,
    output logic signed [CW-1:0]  scalar_out,
    output logic                  zero_divisor,
    output logic                  overflow
);

    // Every request travels the same path regardless of operation, so the
    // results leave in order. The front end does the multiplies, sums and
    // the saturating shift; the square-root pipe then produces the vector
    // length for magnitude and normalize, and the divider pipe produces
    // quotients for divide and normalize. Operations that need neither unit
    // just ride along with their finished result.

    // One shared advance for all stages: move whenever the output register
    // is empty or being emptied this cycle.
    logic   en;

    logic           f_valid;
    pipe_t          f_pipe;
    logic [PW-1:0]  f_sq;
    logic           s_valid;
    pipe_t          s_pipe;
    logic           d_valid;
    pipe_t          d_pipe;
    logic [DW-1:0]  qx, qy, qz;

    logic                  out_valid_reg;
    logic signed [CW-1:0]  rx_reg, ry_reg, rz_reg, sc_reg;
    logic                  zd_reg, ovf_reg;
    logic signed [CW-1:0]  rx_next, ry_next, rz_next, sc_next;
    logic                  zd_next, ovf_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    vau_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (in_valid),
        .operation   (operation),
        .ax          (ax),
        .ay          (ay),
        .az          (az),
        .bx          (bx),
        .by          (by),
        .bz          (bz),
        .scale_value (scale_value),
        .out_valid   (f_valid),
        .out_pipe    (f_pipe),
        .out_sq      (f_sq)
    );

    vau_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_pipe   (f_pipe),
        .in_sq     (f_sq),
        .out_valid (s_valid),
        .out_pipe  (s_pipe)
    );

    vau_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .in_pipe   (s_pipe),
        .out_valid (d_valid),
        .out_pipe  (d_pipe),
        .out_qx    (qx),
        .out_qy    (qy),
        .out_qz    (qz)
    );

    // Final selection. A quotient is negative when the dividend and divisor
    // signs differ; the normalize divisor is a length and never negative.
    // A zero divisor, or a zero length on normalize, hands back A unchanged.
    always_comb
    begin
        logic neg_div;
        sat_t ex, ey, ez;
        neg_div = (d_pipe.op == OP_DIV) && d_pipe.s[CW-1];
        ex = quot_sat(qx, d_pipe.ax[CW-1] ^ neg_div);
        ey = quot_sat(qy, d_pipe.ay[CW-1] ^ neg_div);
        ez = quot_sat(qz, d_pipe.az[CW-1] ^ neg_div);

        rx_next  = d_pipe.rx;
        ry_next  = d_pipe.ry;
        rz_next  = d_pipe.rz;
        sc_next  = d_pipe.sc;
        zd_next  = 1'b0;
        ovf_next = d_pipe.ovf;
        unique case (d_pipe.op) inside
            OP_DIV, OP_NORM:
            begin
                if ((d_pipe.op == OP_DIV && d_pipe.s == '0) ||
                    (d_pipe.op == OP_NORM && d_pipe.root == '0))
                begin
                    rx_next  = d_pipe.ax;
                    ry_next  = d_pipe.ay;
                    rz_next  = d_pipe.az;
                    zd_next  = 1'b1;
                    ovf_next = 1'b0;
                end
                else
                begin
                    rx_next  = ex.val;
                    ry_next  = ey.val;
                    rz_next  = ez.val;
                    ovf_next = ex.ovf | ey.ovf | ez.ovf;
                end
            end
            OP_MAG:
            begin
                // The length can reach past the top of the signed range.
                ovf_next = d_pipe.root[CW-1];
                sc_next  = d_pipe.root[CW-1] ? CMAX : d_pipe.root;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && d_valid)
        begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            rz_reg  <= rz_next;
            sc_reg  <= sc_next;
            zd_reg  <= zd_next;
            ovf_reg <= ovf_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rx           = rx_reg;
    assign ry           = ry_reg;
    assign rz           = rz_reg;
    assign scalar_out   = sc_reg;
    assign zero_divisor = zd_reg;
    assign overflow     = ovf_reg;

endmodule

FILE: src/vau_checker.sv
module vau_checker
    import vau_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_ready,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic signed [CW-1:0]  rx,
    input  logic signed [CW-1:0]  ry,
    input  logic signed [CW-1:0]  rz,
    input  logic signed [CW-1:0]  scalar_out,
    input  logic                  zero_divisor,
    input  logic                  overflow
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rx) && $stable(scalar_out))
        else $error("stalled result changed");

    // The pipeline stops taking requests while the result is stuck.
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request accepted during output stall");

    // A zero-divisor result is A passed through, never saturated.
    a_zd_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_divisor |-> !overflow && scalar_out == '0)
        else $error("zero divisor with overflow or scalar");

    // A result is either a vector or a scalar, never both.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (scalar_out == '0) || (rx == '0 && ry == '0 && rz == '0))
        else $error("vector and scalar both nonzero");

endmodule

bind vector3_arithmetic_unit vau_checker u_vau_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rx           (rx),
    .ry           (ry),
    .rz           (rz),
    .scalar_out   (scalar_out),
    .zero_divisor (zero_divisor),
    .overflow     (overflow)
);

FILE: bench/vector3_arithmetic_unit_test.sv
module vector3_arithmetic_unit_test
    import vau_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 1300;
    // No accepted handshake for this many cycles means the unit is stuck.
    localparam int STALL_LIMIT = 4000;
    // The pipeline is 85 stages deep; drain a little longer than that.
    localparam int DRAIN_CYCLES = 120;

    // One request as presented on the input ports.
    typedef struct {
        logic [3:0]           op;
        logic signed [CW-1:0] ax, ay, az, bx, by, bz, s;
    } request_t;

    // One result as it should appear on the output ports.
    typedef struct {
        logic signed [CW-1:0] rx, ry, rz, sc;
        logic                 zdiv, ovf;
    } vector_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [3:0]           operation;
    logic signed [CW-1:0] ax, ay, az, bx, by, bz, scale_value;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [CW-1:0] rx, ry, rz, scalar_out;
    logic                 zero_divisor;
    logic                 overflow;

    request_t       pending_requests[$];
    vector_result_t expected_results[$];

    int  sender_idle_pct;
    int  receiver_idle_pct;
    int  mismatch_count;
    int  requests_sent;
    int  results_seen;
    int  quiet_cycles;
    bit  stimulus_done;

    vector3_arithmetic_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .ax           (ax),
        .ay           (ay),
        .az           (az),
        .bx           (bx),
        .by           (by),
        .bz           (bz),
        .scale_value  (scale_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rx           (rx),
        .ry           (ry),
        .rz           (rz),
        .scalar_out   (scalar_out),
        .zero_divisor (zero_divisor),
        .overflow     (overflow)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------
    // Golden arithmetic. Everything is carried in wide signed integers so
    // that no intermediate can overflow; the saturation flag is gathered
    // into the result as each component is clamped.
    // ------------------------------------------------------------------

    // Clamp to the component range, noting any saturation.
    function automatic logic signed [CW-1:0] clamp_component(
        input logic signed [127:0] v, inout logic ovf);
        if (v > 128'(CMAX))
        begin
            ovf = 1'b1;
            return CMAX;
        end
        if (v < 128'(CMIN))
        begin
            ovf = 1'b1;
            return CMIN;
        end
        return v[CW-1:0];
    endfunction

    // A sum of full products shifted down by the fraction bits; the
    // arithmetic shift gives rounding toward minus infinity.
    function automatic logic signed [CW-1:0] product_sum(
        input logic signed [127:0] p, inout logic ovf);
        return clamp_component(p >>> FB, ovf);
    endfunction

    // Fixed-point quotient, truncated toward zero as integer division does.
    function automatic logic signed [CW-1:0] fixed_quotient(
        input logic signed [127:0] a, input logic signed [127:0] d, inout logic ovf);
        logic signed [127:0] q;
        q = (a <<< FB) / d;
        return clamp_component(q, ovf);
    endfunction

    // Floor of the square root of a non-negative integer, bit by bit.
    function automatic logic [127:0] floor_sqrt(input logic [127:0] n);
        logic [127:0] root;
        logic [127:0] bitv;
        root = 0;
        bitv = 128'd1 << 126;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic vector_result_t compute_vector_op(input request_t q);
        vector_result_t r;
        logic signed [127:0] a0, a1, a2, b0, b1, b2, s, len;
        r = '{default: '0};
        a0 = q.ax;
        a1 = q.ay;
        a2 = q.az;
        b0 = q.bx;
        b1 = q.by;
        b2 = q.bz;
        s  = q.s;
        case (q.op) inside
            OP_ADD:
            begin
                r.rx = clamp_component(a0 + b0, r.ovf);
                r.ry = clamp_component(a1 + b1, r.ovf);
                r.rz = clamp_component(a2 + b2, r.ovf);
            end
            OP_SUB:
            begin
                r.rx = clamp_component(a0 - b0, r.ovf);
                r.ry = clamp_component(a1 - b1, r.ovf);
                r.rz = clamp_component(a2 - b2, r.ovf);
            end
            OP_SCALE:
            begin
                r.rx = product_sum(a0 * s, r.ovf);
                r.ry = product_sum(a1 * s, r.ovf);
                r.rz = product_sum(a2 * s, r.ovf);
            end
            OP_DIV:
            begin
                if (s == 0)
                begin
                    r.rx = q.ax;
                    r.ry = q.ay;
                    r.rz = q.az;
                    r.zdiv = 1'b1;
                end
                else
                begin
                    r.rx = fixed_quotient(a0, s, r.ovf);
                    r.ry = fixed_quotient(a1, s, r.ovf);
                    r.rz = fixed_quotient(a2, s, r.ovf);
                end
            end
            OP_CROSS:
            begin
                r.rx = product_sum(a1 * b2 - a2 * b1, r.ovf);
                r.ry = product_sum(a2 * b0 - a0 * b2, r.ovf);
                r.rz = product_sum(a0 * b1 - a1 * b0, r.ovf);
            end
            OP_DOT:
                r.sc = product_sum(a0 * b0 + a1 * b1 + a2 * b2, r.ovf);
            OP_LSQ:
                r.sc = product_sum(a0 * a0 + a1 * a1 + a2 * a2, r.ovf);
            OP_MAG, OP_NORM:
            begin
                // The root is taken of the raw integer sum of squares.
                len = floor_sqrt(a0 * a0 + a1 * a1 + a2 * a2);
                if (q.op == OP_MAG)
                    r.sc = clamp_component(len, r.ovf);
                else if (len == 0)
                begin
                    r.rx = q.ax;
                    r.ry = q.ay;
                    r.rz = q.az;
                    r.zdiv = 1'b1;
                end
                else
                begin
                    r.rx = fixed_quotient(a0, len, r.ovf);
                    r.ry = fixed_quotient(a1, len, r.ovf);
                    r.rz = fixed_quotient(a2, len, r.ovf);
                end
            end
            default:
            begin
                // Unused codes produce an all-zero result.
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------

    // Mixes the corner values a fixed-point datapath tends to trip on with
    // small and fully random operands.
    function automatic logic signed [CW-1:0] pick_component();
        case ($urandom_range(0, 9))
            0: return CMAX;
            1: return CMIN;
            2: return 0;
            3: return $urandom_range(0, 1) ? 32'sh0001_0000 : -32'sh0001_0000;
            4: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0001_ffff;
            5: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh007f_ffff;
            6: return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic request_t random_request();
        request_t q;
        // Mostly defined operations, with the unused codes now and then.
        q.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
        q.ax = pick_component();
        q.ay = pick_component();
        q.az = pick_component();
        q.bx = pick_component();
        q.by = pick_component();
        q.bz = pick_component();
        q.s  = pick_component();
        // Make the zero-divisor and zero-vector paths common enough.
        if ($urandom_range(0, 9) == 0)
        begin
            if (q.op == OP_DIV)
                q.s = 0;
            else if (q.op == OP_NORM)
            begin
                q.ax = 0;
                q.ay = 0;
                q.az = 0;
            end
        end
        return q;
    endfunction

    function automatic request_t make_request(input logic [3:0] op,
        input logic signed [CW-1:0] a0, a1, a2, b0, b1, b2, s);
        request_t q;
        q.op = op;
        q.ax = a0;
        q.ay = a1;
        q.az = a2;
        q.bx = b0;
        q.by = b1;
        q.bz = b2;
        q.s  = s;
        return q;
    endfunction

    task automatic wait_until_drained();
        while (pending_requests.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic signed [CW-1:0] one;
        one = 32'sh0001_0000;
        sender_idle_pct   = 21;
        receiver_idle_pct = 57;
        stimulus_done     = 1'b0;
        rst_n = 1'b0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: every operation at the range ends and on the
        // zero-divisor and zero-length special cases.
        pending_requests.push_back(make_request(OP_ADD, CMAX, CMIN, one, one, CMIN, -one, 0));
        pending_requests.push_back(make_request(OP_SUB, CMIN, CMAX, 0, one, CMIN, CMIN, 0));
        pending_requests.push_back(make_request(OP_SCALE, CMAX, CMIN, -one, 0, 0, 0, CMAX));
        pending_requests.push_back(make_request(OP_SCALE, CMIN, -1, 3, 0, 0, 0, CMIN));
        pending_requests.push_back(make_request(OP_SCALE, 5, -5, one, 0, 0, 0, 32'sh0000_8000));
        pending_requests.push_back(make_request(OP_DIV, CMAX, CMIN, 7, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_DIV, CMAX, CMIN, -7, 0, 0, 0, 1));
        pending_requests.push_back(make_request(OP_DIV, CMIN, CMAX, -7, 0, 0, 0, -1));
        pending_requests.push_back(make_request(OP_DIV, CMIN, one, 3, 0, 0, 0, -one));
        pending_requests.push_back(make_request(OP_DIV, CMIN, CMAX, 1, 0, 0, 0, CMIN));
        pending_requests.push_back(make_request(OP_CROSS, one, 0, 0, 0, one, 0, 0));
        pending_requests.push_back(make_request(OP_CROSS, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 0));
        pending_requests.push_back(make_request(OP_DOT, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0));
        pending_requests.push_back(make_request(OP_DOT, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0));
        pending_requests.push_back(make_request(OP_DOT, -1, 1, -1, 1, 1, 1, 0));
        pending_requests.push_back(make_request(OP_LSQ, CMIN, CMIN, CMIN, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_LSQ, one, -one, one, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_MAG, CMIN, CMIN, CMIN, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_MAG, 3, 4, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_MAG, 0, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_NORM, 0, 0, 0, CMAX, CMIN, 1, one));
        pending_requests.push_back(make_request(OP_NORM, CMIN, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_NORM, 1, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_NORM, CMAX, CMAX, -1, 0, 0, 0, 0));
        pending_requests.push_back(make_request(4'd15, CMAX, CMIN, one, one, one, one, one));

        // Random part in three idling phases: a slow receiver, a slow
        // sender, then both at full rate.
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                sender_idle_pct   = 57;
                receiver_idle_pct = 21;
            end
            else if (phase == 2)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            for (int i = 0; i < RANDOM_REQUESTS / 3; i++)
                pending_requests.push_back(random_request());
            wait_until_drained();
        end
        stimulus_done = 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: presents the next pending request and holds it until taken.
    // The decision to show a new request is made once per edge, so valid
    // is never lowered and raised in the same step.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            operation   <= '0;
            ax          <= '0;
            ay          <= '0;
            az          <= '0;
            bx          <= '0;
            by          <= '0;
            bz          <= '0;
            scale_value <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                // The request was accepted at this edge; predict it now.
                expected_results.push_back(compute_vector_op(pending_requests.pop_front()));
                requests_sent++;
            end
            if ((!in_valid || in_ready) && pending_requests.size() != 0
                && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                in_valid    <= 1'b1;
                operation   <= pending_requests[0].op;
                ax          <= pending_requests[0].ax;
                ay          <= pending_requests[0].ay;
                az          <= pending_requests[0].az;
                bx          <= pending_requests[0].bx;
                by          <= pending_requests[0].by;
                bz          <= pending_requests[0].bz;
                scale_value <= pending_requests[0].s;
            end
            else if (in_valid && in_ready)
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest expectation
    // and drives the receiver's random back-pressure.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        vector_result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: result with no request outstanding");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rx !== want.rx || ry !== want.ry || rz !== want.rz
                        || scalar_out !== want.sc || zero_divisor !== want.zdiv
                        || overflow !== want.ovf)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("ERROR: result %0d mismatch", results_seen);
                            $display("  expected r=(%h %h %h) s=%h zdiv=%b ovf=%b",
                                want.rx, want.ry, want.rz, want.sc, want.zdiv, want.ovf);
                            $display("  actual   r=(%h %h %h) s=%h zdiv=%b ovf=%b",
                                rx, ry, rz, scalar_out, zero_divisor, overflow);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: any accepted handshake on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        mismatch_count = 0;
        requests_sent  = 0;
        results_seen   = 0;
        quiet_cycles   = 0;
        fork
            begin
                wait (stimulus_done);
                // Let the pipeline run on so that any spurious result shows up.
                repeat (DRAIN_CYCLES)
                    @(posedge clk);
            end
            begin
                wait (quiet_cycles >= STALL_LIMIT);
                $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
            end
        join_any
        if (!stimulus_done || expected_results.size() != 0)
        begin
            $display("%0d requests sent, %0d results checked, stalled",
                requests_sent, results_seen);
            $display("CHECK FAILED");
        end
        else
        begin
            $display("%0d requests over all nine operations and unused codes, %0d results",
                requests_sent, results_seen);
            $display("three back-pressure phases; %0d mismatches", mismatch_count);
            if (mismatch_count == 0)
                $display("CHECK OK");
            else
                $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
